FILE: sv/chrd_pkg.sv
package chrd_pkg;

    // Largest chunk the position counter has to cover.
    localparam int CHUNK_MAX = 4096;

    // Field and counter widths.
    localparam int BYTE_W = 8;
    localparam int CL_W = 13;
    localparam int MODE_W = 2;
    localparam int AMT_W = 3;
    localparam int POS_W = $clog2(CHUNK_MAX);
    localparam int LEN_W = $clog2(CHUNK_MAX + 1);
    localparam int CMP_W = (LEN_W > CL_W) ? LEN_W : CL_W;
    localparam int CFG_W = CL_W;
    localparam int CFG_IDX_W = 1;

    // Header store geometry.
    localparam int HEADER_DEPTH = 13;
    localparam int HDR_W = $clog2(HEADER_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LENGTH = 1'd1;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THREE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TWO = 2'd3;

    localparam logic [CL_W-1:0] CHUNK_LENGTH_RESET = 13'd1024;

    // Header byte positions used by the derived modes.
    localparam int TWO_POS_A = 0;
    localparam int TWO_POS_B = 1;
    localparam int THREE_POS_A = 2;
    localparam int THREE_POS_B = 11;
    localparam int THREE_POS_C = 12;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              stream_end;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             take;
        logic             flush_load;
        logic [HDR_W-1:0] flush_idx;
        logic             flush_last;
    } chrd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             out_free;
        logic             resolves;
        logic [HDR_W-1:0] held_last;
    } chrd_status_t;

    // Rotate a byte right by the given amount.
    function automatic logic [BYTE_W-1:0] rot_right(input logic [BYTE_W-1:0] b,
                                                    input logic [AMT_W-1:0] r);
        logic [2*BYTE_W-1:0] both;
        both = {b, b} >> r;
        return both[BYTE_W-1:0];
    endfunction

    function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    // Remainder by five of a value below 32.
    function automatic logic [2:0] mod5(input logic [4:0] v);
        logic [4:0] t;
        if (v >= 5'd30)
            t = v - 5'd30;
        else if (v >= 5'd25)
            t = v - 5'd25;
        else if (v >= 5'd20)
            t = v - 5'd20;
        else if (v >= 5'd15)
            t = v - 5'd15;
        else if (v >= 5'd10)
            t = v - 5'd10;
        else if (v >= 5'd5)
            t = v - 5'd5;
        else
            t = v;
        return t[2:0];
    endfunction

    // Rotation table of the two-byte mode.
    function automatic logic [AMT_W-1:0] two_byte_map(input logic [2:0] k);
        logic [AMT_W-1:0] r;
        case (k)
            3'd0: r = 3'd1;
            3'd1: r = 3'd7;
            3'd2: r = 3'd2;
            3'd3: r = 3'd6;
            3'd4: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Rotation table of the three-byte mode.
    function automatic logic [AMT_W-1:0] three_byte_map(input logic [2:0] k);
        logic [AMT_W-1:0] r;
        case (k)
            3'd0: r = 3'd7;
            3'd1: r = 3'd1;
            3'd2: r = 3'd6;
            3'd3: r = 3'd2;
            3'd4: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/chrd_ctrl.sv
module chrd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  chrd_pkg::chrd_status_t status,
    output chrd_pkg::chrd_cmd_t    cmd
);
    import chrd_pkg::*;

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic             state_reg, state_next;
    logic [HDR_W-1:0] idx_reg, idx_next;
    logic [HDR_W-1:0] last_reg, last_next;
    logic             accept;
    logic             flush_step;

    // Intake is open only while streaming and the output register can load.
    assign accept = in_valid && (state_reg == ST_RUN) && status.out_free;
    assign flush_step = (state_reg == ST_FLUSH) && status.out_free;
    assign in_stall = !((state_reg == ST_RUN) && status.out_free);

    assign cmd.take = accept;
    assign cmd.flush_load = flush_step;
    assign cmd.flush_idx = idx_reg;
    assign cmd.flush_last = (idx_reg == last_reg);

    // Next state: a resolving beat starts a flush of the held header bytes.
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        last_next = last_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && status.resolves)
                begin
                    state_next = ST_FLUSH;
                    idx_next = '0;
                    last_next = status.held_last;
                end
            end
            ST_FLUSH:
            begin
                if (flush_step)
                begin
                    idx_next = idx_reg + HDR_W'(1);
                    if (idx_reg == last_reg)
                        state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            idx_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            last_reg <= last_next;
        end
    end

endmodule

FILE: sv/chrd_datapath.sv
module chrd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [chrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [chrd_pkg::CFG_W-1:0]     cfg_data,
    input  chrd_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output chrd_pkg::out_item_t            out_data,
    input  chrd_pkg::chrd_cmd_t            cmd,
    output chrd_pkg::chrd_status_t         status
);
    import chrd_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [CL_W-1:0]   chunk_length_reg;
    logic [BYTE_W-1:0] header_store_reg [HEADER_DEPTH];
    logic [POS_W-1:0]  chunk_position_reg, chunk_position_next;
    logic [AMT_W-1:0]  rotation_amount_reg, rotation_amount_next;
    logic              rotation_ready_reg, rotation_ready_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  eff_len;
    logic [CMP_W-1:0]  pos_plus;
    logic              chunk_ends;
    logic [BYTE_W-1:0] byte_b;
    logic [BYTE_W-1:0] byte_c;
    logic [4:0]        plus_cnt;
    logic [4:0]        minus_cnt;
    logic [4:0]        diff3;
    logic [3:0]        pc_a;
    logic [3:0]        pc_b;
    logic [4:0]        diff2;
    logic              resolved;
    logic [AMT_W-1:0]  amt;
    logic              out_free;
    logic              direct_load;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PASS;
            chunk_length_reg <= CHUNK_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:
                    mode_reg <= cfg_data[MODE_W-1:0];
                REG_CHUNK_LENGTH:
                    chunk_length_reg <= cfg_data[CL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Chunk end: the byte fills the clamped length, or the stream ends.
    always_comb
    begin
        len_ext = CMP_W'(chunk_length_reg);
        if (len_ext == '0)
            eff_len = CMP_W'(1);
        else if (len_ext > CMP_W'(CHUNK_MAX))
            eff_len = CMP_W'(CHUNK_MAX);
        else
            eff_len = len_ext;
        pos_plus = CMP_W'(chunk_position_reg) + CMP_W'(1);
        chunk_ends = (pos_plus >= eff_len) || in_data.stream_end;
    end

    // Rotation amount of the current chunk, with the current byte bypassed.
    always_comb
    begin
        byte_b = (chunk_position_reg == POS_W'(TWO_POS_B))
                 ? in_data.in_byte : header_store_reg[TWO_POS_B];
        byte_c = (chunk_position_reg == POS_W'(THREE_POS_C))
                 ? in_data.in_byte : header_store_reg[THREE_POS_C];
        pc_a = popcount8(header_store_reg[TWO_POS_A]);
        pc_b = popcount8(byte_b);
        diff2 = (pc_b >= pc_a) ? {1'b0, pc_b - pc_a} : {1'b0, pc_a - pc_b};
        plus_cnt = {1'b0, popcount8(header_store_reg[THREE_POS_A])}
                   + {1'b0, popcount8(byte_c)};
        minus_cnt = {1'b0, popcount8(header_store_reg[THREE_POS_B])};
        diff3 = (plus_cnt >= minus_cnt) ? plus_cnt - minus_cnt : minus_cnt - plus_cnt;

        resolved = 1'b0;
        amt = '0;
        case (mode_reg)
            MODE_PASS:
            begin
                resolved = 1'b1;
                amt = '0;
            end
            MODE_FIVE:
            begin
                resolved = 1'b1;
                amt = 3'd5;
            end
            MODE_TWO:
            begin
                if (chunk_position_reg >= POS_W'(TWO_POS_B))
                begin
                    resolved = 1'b1;
                    if ((header_store_reg[TWO_POS_A] == '0) && (byte_b == '0))
                        amt = '0;
                    else
                        amt = two_byte_map(mod5(diff2));
                end
            end
            MODE_THREE:
            begin
                if (chunk_position_reg >= POS_W'(THREE_POS_C))
                begin
                    resolved = 1'b1;
                    amt = three_byte_map(mod5(diff3));
                end
            end
            default:
            begin
            end
        endcase

        // A chunk that closes before its amount is known uses no rotation.
        if (!resolved && chunk_ends)
        begin
            resolved = 1'b1;
            amt = '0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign direct_load = cmd.take && rotation_ready_reg;

    assign status.out_free = out_free;
    assign status.resolves = !rotation_ready_reg && resolved;
    assign status.held_last = (chunk_position_reg < POS_W'(HEADER_DEPTH - 1))
                              ? chunk_position_reg[HDR_W-1:0]
                              : HDR_W'(HEADER_DEPTH - 1);

    // Header store: bytes seen before the amount is known.
    always_ff @(posedge clk)
    begin
        if (cmd.take && !rotation_ready_reg
            && (chunk_position_reg < POS_W'(HEADER_DEPTH)))
            header_store_reg[chunk_position_reg[HDR_W-1:0]] <= in_data.in_byte;
    end

    // Chunk position and rotation state.
    always_comb
    begin
        chunk_position_next = chunk_position_reg;
        rotation_amount_next = rotation_amount_reg;
        rotation_ready_next = rotation_ready_reg;
        if (cmd.take)
        begin
            if (!rotation_ready_reg && resolved)
            begin
                rotation_amount_next = amt;
                rotation_ready_next = 1'b1;
            end
            if (chunk_ends)
            begin
                chunk_position_next = '0;
                rotation_ready_next = 1'b0;
            end
            else
            begin
                chunk_position_next = pos_plus[POS_W-1:0];
            end
        end
    end

    // Output register: loaded by a direct beat or one flush beat.
    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (direct_load)
        begin
            out_data_next.out_byte = rot_right(in_data.in_byte, rotation_amount_reg);
            out_data_next.run_last = 1'b1;
            out_valid_next = 1'b1;
        end
        else if (cmd.flush_load)
        begin
            out_data_next.out_byte = rot_right(header_store_reg[cmd.flush_idx],
                                               rotation_amount_reg);
            out_data_next.run_last = cmd.flush_last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_position_reg <= '0;
            rotation_amount_reg <= '0;
            rotation_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chunk_position_reg <= chunk_position_next;
            rotation_amount_reg <= rotation_amount_next;
            rotation_ready_reg <= rotation_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

FILE: sv/chunked_rotation_descrambler.sv
// Chunked rotation descrambler.
// Input channel: in_valid / in_stall with in_data (in_byte, stream_end); a beat
// moves when in_valid is high and in_stall is low. Output channel: out_valid /
// out_stall with out_data (out_byte, run_last), same rule, stall from the sink.
// Configuration: cfg_write with cfg_index 0 (mode) or 1 (chunk_length) and
// cfg_data. Users must write only while the block is idle; nothing enforces it.
// Once a chunk's rotation is known, each input beat yields one output beat in
// the cycle after it; unless the sink stalls, one byte is taken per cycle.
// Header bytes that arrive before the rotation is known are held; the beat that
// fixes the rotation starts a flush of 1 to 13 held bytes from the header store,
// one per cycle through the single output register while the sink does not
// stall, and intake stalls during the flush.
// When the receiver stalls, the output register holds its beat and intake
// stalls too, since the output register is the only buffer.
// Reset clears the chunk position, the rotation state, the output valid and the
// controller, and sets mode 0 and chunk length 1024.
module chunked_rotation_descrambler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [chrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [chrd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  chrd_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output chrd_pkg::out_item_t            out_data
);
    import chrd_pkg::*;

    chrd_cmd_t    cmd;
    chrd_status_t status;

    // Sequencing of intake and header flush.
    chrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Header store, rotation decision and output register.
    chrd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
